FILE: design/assert_macros.svh
// Assertion macros used by the top level RTL file of the radix digit formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SITRD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SITRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/sitrd_pkg.sv
// Package with types, constants and the symbol lookup of the radix digit formatter.
`default_nettype none

package sitrd_pkg;

    // Widths and limits of the data path.
    localparam int VALUE_W           = 32;
    localparam int MAX_DIGITS        = 32;
    localparam int DIV_STEP          = 4;
    localparam int TABLE_SIZE        = 16;
    localparam int DEFAULT_MAX_RADIX = 16;
    localparam int RADIX_W           = 5;
    localparam int SYM_WORD_W        = 64;
    localparam int CHAR_W            = 8;
    localparam int CFG_IDX_W         = 2;

    // Special characters.
    localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_HIGH = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    // Status of the symbol table check.
    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_status;

    // Result of one division step sequence.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
    } t_div_res;

    // Byte idx of the sixteen entry symbol table.
    function automatic logic [CHAR_W-1:0] sym_at(
        input logic [SYM_WORD_W-1:0] lo,
        input logic [SYM_WORD_W-1:0] hi,
        input logic [3:0]            idx
    );
        logic [SYM_WORD_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

FILE: design/sitrd_validator.sv
// Symbol table checker: walks the table one symbol per cycle against the symbols above it and the signs.
`default_nettype none

module sitrd_validator #(
    parameter int MAX_RADIX = sitrd_pkg::DEFAULT_MAX_RADIX
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [sitrd_pkg::RADIX_W-1:0]       i_radix,
    input  wire logic [sitrd_pkg::SYM_WORD_W-1:0]    i_sym_lo,
    input  wire logic [sitrd_pkg::SYM_WORD_W-1:0]    i_sym_hi,
    output sitrd_pkg::t_chk_status                   o_status
);
    import sitrd_pkg::*;

    localparam int IW = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;

    logic          r_busy;
    logic          r_bad;
    logic          r_done;
    logic          r_ok;
    logic [IW-1:0] r_idx;
    logic          w_hit;

    // Flag the current symbol if it is a sign or repeats at a higher position in use.
    always_comb begin
        logic [CHAR_W-1:0] s;
        logic              in_use;
        s      = sym_at(i_sym_lo, i_sym_hi, 4'(r_idx));
        in_use = RADIX_W'(r_idx) < i_radix;
        w_hit  = 1'b0;
        if (in_use) begin
            if (s == SYM_PLUS || s == SYM_MINUS) begin
                w_hit = 1'b1;
            end
            for (int j = 0; j < MAX_RADIX; j++) begin
                if (RADIX_W'(j) > RADIX_W'(r_idx) && RADIX_W'(j) < i_radix &&
                    sym_at(i_sym_lo, i_sym_hi, 4'(j)) == s) begin
                    w_hit = 1'b1;
                end
            end
        end
    end

    // Sequencing of the walk over the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
            r_bad  <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_bad  <= (i_radix < RADIX_W'(2)) || (i_radix > RADIX_W'(MAX_RADIX));
            end else if (r_busy) begin
                r_bad <= r_bad | w_hit;
                r_idx <= IW'(r_idx + 1'b1);
                if (r_idx == IW'(MAX_RADIX - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_ok   <= !(r_bad | w_hit);
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.ok   = r_ok;

endmodule

`default_nettype wire

FILE: design/sitrd_divider.sv
// Iterative divider: DIV_STEP restoring division steps per cycle by the radix.
`default_nettype none

module sitrd_divider #(
    parameter int MAX_RADIX = sitrd_pkg::DEFAULT_MAX_RADIX
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [sitrd_pkg::VALUE_W-1:0]    i_dividend,
    input  wire logic [sitrd_pkg::RADIX_W-1:0]    i_radix,
    output sitrd_pkg::t_div_res                   o_res,
    output logic [$clog2(MAX_RADIX)-1:0]          o_rem
);
    import sitrd_pkg::*;

    localparam int DW    = $clog2(MAX_RADIX);
    localparam int STEPS = VALUE_W / DIV_STEP;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [VALUE_W-1:0] r_q;
    logic [DW-1:0]      r_rem;
    logic [VALUE_W-1:0] w_q;
    logic [DW-1:0]      w_rem;

    // Shift dividend bits into the remainder, subtract the radix where it fits.
    always_comb begin
        logic [DW:0]        t;
        logic [DW:0]        rad;
        logic [VALUE_W-1:0] q;
        logic [DW-1:0]      rem;
        rad = i_radix[DW:0];
        q   = r_q;
        rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            t = {rem, q[VALUE_W-1]};
            q = {q[VALUE_W-2:0], 1'b0};
            if (t >= rad) begin
                t    = t - rad;
                q[0] = 1'b1;
            end
            rem = t[DW-1:0];
        end
        w_q   = q;
        w_rem = rem;
    end

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= w_q;
            r_rem <= w_rem;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_q;
    assign o_rem          = r_rem;

endmodule

`default_nettype wire

FILE: design/signed_int_to_radix_digits.sv
// Top level: checks the base, divides out the digits and sends the text a byte per transfer.
// The symbol table is checked first; each digit is then divided out four quotient bits per
// divider step and handed off to the digit store. The input stays stalled until the last
// byte is loaded for output, longer for a minus sign and for each output stall; a bad base or
// symbol table sends nothing and returns to idle after the check. Reset is synchronous and
// active low; it clears the sequencer, the output valid flag and the three configuration registers.
`default_nettype none

module signed_int_to_radix_digits #(
    parameter int MAX_RADIX = sitrd_pkg::DEFAULT_MAX_RADIX
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [sitrd_pkg::VALUE_W-1:0] i_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [sitrd_pkg::CHAR_W-1:0]              o_character,
    output logic                                      o_last,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [sitrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sitrd_pkg::SYM_WORD_W-1:0]     i_cfg_data
);
    import sitrd_pkg::*;

    `include "assert_macros.svh"

    localparam int DW  = $clog2(MAX_RADIX);
    localparam int NDW = $clog2(MAX_DIGITS + 1);
    localparam int AW  = $clog2(MAX_DIGITS);

    t_state              r_state,     n_state;
    logic                r_neg,       n_neg;
    logic [VALUE_W-1:0]  r_mag,       n_mag;
    logic [NDW-1:0]      r_nd,        n_nd;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_char,  n_out_char;
    logic                r_out_last,  n_out_last;
    logic [RADIX_W-1:0]  r_radix;
    logic [SYM_WORD_W-1:0] r_sym_lo;
    logic [SYM_WORD_W-1:0] r_sym_hi;
    logic [DW-1:0]       r_digits [MAX_DIGITS];
    logic [DW-1:0]       r_rd_digit;

    logic                w_chk_start;
    logic                w_div_start;
    logic                w_dig_we;
    logic                w_slot_free;
    logic [VALUE_W-1:0]  w_raw;
    logic [VALUE_W-1:0]  w_div_in;
    logic [NDW-1:0]      w_nd_dec;
    logic [AW-1:0]       w_rd_addr;
    logic [DW-1:0]       w_div_rem;
    t_chk_status         w_chk;
    t_div_res            w_div;

    // Configuration registers; writes are always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= '0;
            r_sym_lo <= '0;
            r_sym_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIX:    r_radix  <= i_cfg_data[RADIX_W-1:0];
                CFG_SYM_LOW:  r_sym_lo <= i_cfg_data;
                CFG_SYM_HIGH: r_sym_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Symbol table check and the divider, reused for every digit.
    sitrd_validator #(
        .MAX_RADIX(MAX_RADIX)
    ) u_validator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_chk_start),
        .i_radix  (r_radix),
        .i_sym_lo (r_sym_lo),
        .i_sym_hi (r_sym_hi),
        .o_status (w_chk)
    );

    assign w_div_in = (r_state == S_DIV) ? w_div.quotient : r_mag;

    sitrd_divider #(
        .MAX_RADIX(MAX_RADIX)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .i_radix    (r_radix),
        .o_res      (w_div),
        .o_rem      (w_div_rem)
    );

    // Digit store, filled least significant first and read back in reverse. The read
    // register follows the next digit count and passes on a digit written at the same edge.
    always_ff @(posedge i_clk) begin
        if (w_dig_we) begin
            r_digits[r_nd[AW-1:0]] <= w_div_rem;
        end
        if (w_dig_we && (w_rd_addr == r_nd[AW-1:0])) begin
            r_rd_digit <= w_div_rem;
        end else begin
            r_rd_digit <= r_digits[w_rd_addr];
        end
    end

    assign w_nd_dec   = NDW'(r_nd - 1'b1);
    assign w_rd_addr  = AW'(n_nd - 1'b1);
    assign w_raw      = unsigned'(i_value);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Sequencer: next state, output register loads and unit starts.
    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_nd        = r_nd;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_chk_start = 1'b0;
        w_div_start = 1'b0;
        w_dig_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_neg       = w_raw[VALUE_W-1];
                    n_mag       = w_raw[VALUE_W-1] ? (VALUE_W'(0) - w_raw) : w_raw;
                    w_chk_start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_chk.done) begin
                    if (w_chk.ok) begin
                        w_div_start = 1'b1;
                        n_nd        = '0;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_dig_we = 1'b1;
                    n_nd     = NDW'(r_nd + 1'b1);
                    if (w_div.quotient != '0 && r_nd < NDW'(MAX_DIGITS - 1)) begin
                        w_div_start = 1'b1;
                    end else begin
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = SYM_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = sym_at(r_sym_lo, r_sym_hi, 4'(r_rd_digit));
                    n_out_last  = (r_nd == NDW'(1));
                    n_nd        = w_nd_dec;
                    if (r_nd == NDW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nd        <= n_nd;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

    // The units report only in the state that waits for them.
    `SITRD_ASSERT(a_chk_done_in_check, i_clk, i_rst_n, w_chk.done |-> (r_state == S_CHECK),
                  "table check finished outside the check state")
    `SITRD_ASSERT(a_div_done_in_div, i_clk, i_rst_n, w_div.done |-> (r_state == S_DIV),
                  "divider finished outside the divide state")
    // Emission always has a stored digit left.
    `SITRD_ASSERT(a_emit_has_digit, i_clk, i_rst_n, (r_state == S_EMIT) |-> (r_nd != '0),
                  "digit emission with an empty digit store")

endmodule

`default_nettype wire
